### src/lpht_pkg.sv
package lpht_pkg;

  localparam int KEY_W          = 31;
  localparam int CFG_W          = 9;
  localparam int FUNC_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int MARK_W         = 2;
  localparam int SLOT_OUT_W     = 8;
  localparam int SLOTS_DEF      = 256;
  localparam int VALUE_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

endpackage

### src/lpht_mod.sv
module lpht_mod
  import lpht_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [CFG_W-1:0] modulus,
  output logic             done,
  output logic [CFG_W-1:0] remainder
);

  localparam int CNT_W = $clog2(KEY_W);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] shreg;
  logic [CFG_W:0]   trial;

  assign trial = {remainder, shreg[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(KEY_W - 1);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // restoring remainder, one key bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      remainder <= '0;
    end else if (active) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, modulus}) begin
        remainder <= CFG_W'(trial - {1'b0, modulus});
      end else begin
        remainder <= CFG_W'(trial);
      end
    end
  end

endmodule

### src/lpht_store.sv
module lpht_store
  import lpht_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int WORD_W = MARK_W + KEY_W + VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [WORD_W-1:0]        rd_data
);

  logic [WORD_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/linear_probe_hash_table.sv
// Open-addressing key/value table with linear probing and tombstones. An item
// (insert, delete or search) is taken when start is high and busy is low; its
// single result appears on status, found_value and slot_index for exactly one
// cycle with done high, and cannot be stalled. The home slot is key mod
// slots_in_use (0 taken as 1, values above SLOTS as SLOTS), computed by a
// bit-serial remainder unit, after which each probe is a registered slot memory
// read, then the compare and any write. The next item can be taken while done
// is high; an unknown func is answered with a miss in the cycle after it is
// taken, without hashing. After reset a clearing pass walks the slot memory
// with busy high; cfg_wr_en writes are taken at any time.
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  start,
  input  logic [FUNC_W-1:0]     func,
  input  logic [KEY_W-1:0]      key,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  busy,
  output logic                  done,
  output logic [STATUS_W-1:0]   status,
  output logic [VALUE_BITS-1:0] found_value,
  output logic [SLOT_OUT_W-1:0] slot_index
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int WORD_W = MARK_W + KEY_W + VALUE_BITS;
  localparam int CMP_W  = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;

  logic [2:0]            state;
  logic [CFG_W-1:0]      slots_in_use;
  logic [CFG_W-1:0]      n_reg;
  logic [CFG_W-1:0]      n_eff;
  logic [CFG_W-1:0]      remain;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      clr_cnt;
  logic [IDX_W:0]        idx_inc;
  logic                  idx_wrap;
  logic [FUNC_W-1:0]     op_func;
  logic [KEY_W-1:0]      op_key;
  logic [VALUE_BITS-1:0] op_value;

  logic                  accept;
  logic                  func_ok;
  logic                  mod_start;
  logic                  mod_done;
  logic [CFG_W-1:0]      mod_rem;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_W-1:0]     wr_data;
  logic [WORD_W-1:0]     rd_data;
  logic [MARK_W-1:0]     rd_mark;
  logic [KEY_W-1:0]      rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic                  key_hit;
  logic                  ins_take;
  logic                  del_take;

  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);
  assign func_ok   = (func == FUNC_INSERT) || (func == FUNC_DELETE) || (func == FUNC_SEARCH);
  assign mod_start = accept && func_ok;

  always_comb begin
    if (slots_in_use == '0) begin
      n_eff = CFG_W'(1);
    end else if (32'(slots_in_use) > 32'(SLOTS)) begin
      n_eff = CFG_W'(SLOTS);
    end else begin
      n_eff = slots_in_use;
    end
  end

  assign idx_inc  = {1'b0, idx} + 1'b1;
  assign idx_wrap = (CMP_W'(idx_inc) == CMP_W'(n_reg));

  assign rd_mark  = rd_data[WORD_W-1 -: MARK_W];
  assign rd_key   = rd_data[VALUE_BITS +: KEY_W];
  assign rd_value = rd_data[VALUE_BITS-1:0];
  assign key_hit  = (rd_mark == MARK_USED) && (rd_key == op_key);
  assign ins_take = (op_func == FUNC_INSERT) && (rd_mark == MARK_EMPTY);
  assign del_take = (op_func == FUNC_DELETE) && key_hit;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = {MARK_GONE, rd_key, rd_value};
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = {MARK_EMPTY, KEY_W'(0), VALUE_BITS'(0)};
    end else if (state == S_CHECK) begin
      wr_en = ins_take || del_take;
      if (ins_take) begin
        wr_data = {MARK_USED, op_key, op_value};
      end
    end
  end

  lpht_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (key),
    .modulus   (n_reg),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  lpht_store #(
    .SLOTS  (SLOTS),
    .WORD_W (WORD_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CFG_RESET;
    end else if (cfg_wr_en) begin
      slots_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDX_W'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_func  <= func;
            op_key   <= key;
            op_value <= value;
            n_reg    <= n_eff;
            remain   <= n_eff;
            if (func_ok) begin
              state <= S_HASH;
            end else begin
              done        <= 1'b1;
              status      <= STATUS_MISS;
              found_value <= '0;
              slot_index  <= '0;
            end
          end
        end
        S_HASH: begin
          if (mod_done) begin
            idx   <= IDX_W'(mod_rem);
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          priority if (ins_take || del_take) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= STATUS_OK;
            found_value <= '0;
            slot_index  <= SLOT_OUT_W'(idx);
          end else if (rd_mark == MARK_EMPTY) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= STATUS_MISS;
            found_value <= '0;
            slot_index  <= '0;
          end else if ((op_func == FUNC_SEARCH) && key_hit) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= STATUS_OK;
            found_value <= rd_value;
            slot_index  <= SLOT_OUT_W'(idx);
          end else if (remain == CFG_W'(1)) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= (op_func == FUNC_INSERT) ? STATUS_FULL : STATUS_MISS;
            found_value <= '0;
            slot_index  <= '0;
          end else begin
            remain <= remain - 1'b1;
            idx    <= idx_wrap ? '0 : IDX_W'(idx_inc);
            state  <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/lpht_checker.sv
module lpht_checker
  import lpht_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic [STATUS_W-1:0]   status,
  input logic [VALUE_BITS-1:0] found_value,
  input logic [SLOT_OUT_W-1:0] slot_index
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STATUS_OK) || (status == STATUS_MISS) || (status == STATUS_FULL))
    else $error("result status code out of range");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && (status != STATUS_OK) |-> (found_value == '0) && (slot_index == '0))
    else $error("failed item carries a value or slot");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted item neither in work nor answered");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

endmodule

bind linear_probe_hash_table lpht_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .found_value (found_value),
  .slot_index  (slot_index)
);
